/* rtl/layer_gain_crossfade_controller_assert.svh */
// Assertion macros for the crossfade controller checker.
`ifndef LAYER_GAIN_CROSSFADE_CONTROLLER_ASSERT_SVH
`define LAYER_GAIN_CROSSFADE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define LGC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lgc assertion failed");

// Next-cycle implication, disabled in reset.
`define LGC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lgc assertion failed");

`endif

/* rtl/lgc_pkg.sv */
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared types, codes and constants of the layer gain crossfade controller.
// ----------------------------------------------------------------------------
`default_nettype none
package lgc_pkg;

  localparam int DEF_MAX_STATES   = 16;
  localparam int DEF_MAX_LAYERS   = 8;
  localparam int DEF_MAX_STINGERS = 16;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam int          CMP_W   = 8;   // compare width for counts and indices
  localparam int          DVD_W   = 31;  // dt * 32768 fits in 31 bits

  typedef enum logic [2:0] {
    MODE_GAIN_WR  = 3'd0,
    MODE_TIME_WR  = 3'd1,
    MODE_STING_WR = 3'd2,
    MODE_SELECT   = 3'd3,
    MODE_LEVEL    = 3'd4,
    MODE_TICK     = 3'd5,
    MODE_READ     = 3'd6,
    MODE_TRIGGER  = 3'd7
  } mode_e;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_STATE = 2'd1;
  localparam logic [1:0] ST_BAD_STING = 2'd2;
  localparam logic [1:0] ST_RANGE     = 2'd3;

  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_STATE   = 2'd1;
  localparam logic [1:0] EV_STINGER = 2'd2;

  localparam logic [1:0] REG_STATES   = 2'd0;
  localparam logic [1:0] REG_LAYERS   = 2'd1;
  localparam logic [1:0] REG_STINGERS = 2'd2;

  typedef struct packed {
    logic [4:0] states;
    logic [3:0] layers;
    logic [4:0] stingers;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  index;
    logic [2:0]  layer_sel;
    logic        layer_given;
    logic [15:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  event_kind;
    logic [3:0]  event_index;
    logic [2:0]  event_layer;
    logic        event_layer_given;
    logic [15:0] event_level;
    logic [15:0] gain_out;
    logic [3:0]  settled_state;
    logic        settled_valid;
    logic        fading;
  } res_t;

endpackage
`default_nettype wire

/* rtl/lgc_div.sv */
// ----------------------------------------------------------------------------
// lgc_div
// Restoring divider, one quotient bit per cycle, for the fade increment.
// ----------------------------------------------------------------------------
`default_nettype none
module lgc_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start_i,
  input  wire logic [lgc_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [15:0]              divisor_i,
  output logic                          done_o,
  output logic [lgc_pkg::DVD_W-1:0]     quot_o
);
  import lgc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [15:0]      rem_r;
  logic [15:0]      dsr_r;
  logic [DVD_W-1:0] q_r;
  logic [16:0]      rem_sh;
  logic [16:0]      diff;
  logic             qbit;

  always_comb begin
    rem_sh = {rem_r, q_r[DVD_W-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    qbit   = (rem_sh >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      dsr_r  <= '0;
      q_r    <= '0;
    end else begin
      done_r <= !start_i && busy_r && (cnt_r == '0);
      if (start_i) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
        rem_r  <= '0;
        dsr_r  <= divisor_i;
        q_r    <= dividend_i;
      end else if (busy_r) begin
        rem_r <= qbit ? diff[15:0] : rem_sh[15:0];
        q_r   <= {q_r[DVD_W-2:0], qbit};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = q_r;
endmodule
`default_nettype wire

/* rtl/lgc_core.sv */
// ----------------------------------------------------------------------------
// lgc_core
// Sequencer around the gain, time, stinger and per-layer memories.
// ----------------------------------------------------------------------------
`default_nettype none
module lgc_core #(
  parameter int MAX_STATES   = lgc_pkg::DEF_MAX_STATES,
  parameter int MAX_LAYERS   = lgc_pkg::DEF_MAX_LAYERS,
  parameter int MAX_STINGERS = lgc_pkg::DEF_MAX_STINGERS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lgc_pkg::cfg_t  cfg_i,
  input  wire logic           start_i,
  input  wire lgc_pkg::item_t item_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  wire logic           res_take_i,
  output lgc_pkg::res_t       res_o
);
  import lgc_pkg::*;

  localparam int GDEPTH = MAX_STATES * MAX_LAYERS;
  localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
  localparam int TA_W   = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int SA_W   = (MAX_STINGERS > 1) ? $clog2(MAX_STINGERS) : 1;
  localparam int LW     = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_TCHK, S_SRD, S_DIV, S_LRD, S_LWR,
    S_GM1, S_GM2, S_GM3, S_DONE
  } st_t;

  // memories
  logic [15:0] gmem [GDEPTH];
  logic [15:0] tmem [MAX_STATES];
  logic [19:0] smem [MAX_STINGERS];
  logic [47:0] lmem [MAX_LAYERS];   // settled, fade start, fade end
  logic [15:0] gmem_q;
  logic [15:0] tmem_q;
  logic [19:0] smem_q;
  logic [47:0] lmem_q;

  logic            g_we, t_we, s_we, l_we;
  logic [GA_W-1:0] g_waddr, g_raddr;
  logic [TA_W-1:0] t_waddr, t_raddr;
  logic [SA_W-1:0] s_waddr, s_raddr;
  logic [LW-1:0]   l_waddr, l_raddr;
  logic [15:0]     g_wdata, t_wdata;
  logic [19:0]     s_wdata;
  logic [47:0]     l_wdata;

  st_t             st_r;
  logic [GA_W-1:0] clr_r;
  item_t           it_r;
  logic [LW-1:0]   lc_r;
  logic [15:0]     time_r;
  logic [15:0]     master_r;
  logic [15:0]     prog_r;
  logic [3:0]      cur_r;
  logic            cur_v_r;
  logic [3:0]      pend_r;
  logic            pend_v_r;
  logic [31:0]     acc_r;
  res_t            res_r;

  logic [CMP_W-1:0] n_states, n_layers, n_stingers;
  logic             over_one;
  logic [15:0]      tgt;
  logic [15:0]      mul_a, mul_b;
  logic [31:0]      mul_p;
  logic             div_start, div_done;
  logic [DVD_W-1:0] quot;
  logic [31:0]      psum;

  lgc_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i ({it_r.value, 15'd0}),
    .divisor_i  (tmem_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    n_states   = (CMP_W'(cfg_i.states) < CMP_W'(MAX_STATES)) ?
                 CMP_W'(cfg_i.states) : CMP_W'(MAX_STATES);
    n_layers   = (CMP_W'(cfg_i.layers) < CMP_W'(MAX_LAYERS)) ?
                 CMP_W'(cfg_i.layers) : CMP_W'(MAX_LAYERS);
    n_stingers = (CMP_W'(cfg_i.stingers) < CMP_W'(MAX_STINGERS)) ?
                 CMP_W'(cfg_i.stingers) : CMP_W'(MAX_STINGERS);
    over_one   = (it_r.value > ONE_Q15);
    tgt        = (CMP_W'(lc_r) < n_layers) ? gmem_q : 16'd0;
    psum       = {16'd0, prog_r} + {1'b0, quot};
  end

  // memory controls
  always_comb begin
    g_we = 1'b0; t_we = 1'b0; s_we = 1'b0; l_we = 1'b0;
    g_waddr = GA_W'(int'(it_r.index) * MAX_LAYERS + int'(it_r.layer_sel));
    t_waddr = TA_W'(it_r.index);
    s_waddr = SA_W'(it_r.index);
    l_waddr = lc_r;
    g_wdata = it_r.value;
    t_wdata = it_r.value;
    s_wdata = {it_r.layer_given, it_r.layer_sel, it_r.value};
    l_wdata = lmem_q;
    g_raddr = GA_W'(int'(it_r.index) * MAX_LAYERS + int'(lc_r));
    t_raddr = (it_r.mode == MODE_TICK) ? TA_W'(pend_r) : TA_W'(it_r.index);
    s_raddr = SA_W'(it_r.index);
    l_raddr = (st_r == S_EXEC || st_r == S_GM1) ? LW'(it_r.layer_sel) : lc_r;
    case (st_r)
      S_CLEAR: begin
        g_waddr = clr_r;
        t_waddr = TA_W'(clr_r);
        s_waddr = SA_W'(clr_r);
        l_waddr = LW'(clr_r);
        g_wdata = '0; t_wdata = '0; s_wdata = '0; l_wdata = '0;
        g_we    = 1'b1;
        t_we    = (int'(clr_r) < MAX_STATES);
        s_we    = (int'(clr_r) < MAX_STINGERS);
        l_we    = (int'(clr_r) < MAX_LAYERS);
      end
      S_EXEC: begin
        case (it_r.mode)
          MODE_GAIN_WR:  g_we = (CMP_W'(it_r.index) < CMP_W'(MAX_STATES)) && !over_one &&
                                (CMP_W'(it_r.layer_sel) < CMP_W'(MAX_LAYERS));
          MODE_TIME_WR:  t_we = (CMP_W'(it_r.index) < CMP_W'(MAX_STATES));
          MODE_STING_WR: s_we = (CMP_W'(it_r.index) < CMP_W'(MAX_STINGERS)) && !over_one;
          default: ;
        endcase
      end
      S_LWR: begin
        l_we = 1'b1;
        if (it_r.mode == MODE_SELECT) begin
          if (time_r == 16'd0) l_wdata = {tgt, lmem_q[31:0]};
          else                 l_wdata = {lmem_q[47:32], lmem_q[47:32], tgt};
        end else begin
          l_wdata = {lmem_q[15:0], lmem_q[31:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    gmem_q <= gmem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (t_we) tmem[t_waddr] <= t_wdata;
    tmem_q <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    smem_q <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) lmem[l_waddr] <= l_wdata;
    lmem_q <= lmem[l_raddr];
  end

  // shared multiplier
  always_comb begin
    mul_a = acc_r[30:15];
    mul_b = master_r;
    case (st_r)
      S_GM1:   begin mul_a = lmem_q[31:16]; mul_b = ONE_Q15 - prog_r; end
      S_GM2:   begin mul_a = lmem_q[15:0];  mul_b = prog_r;           end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  assign div_start = (st_r == S_TCHK) && (it_r.mode == MODE_TICK) && (tmem_q != 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLEAR;
      clr_r    <= '0;
      it_r     <= '0;
      lc_r     <= '0;
      time_r   <= '0;
      master_r <= ONE_Q15;
      prog_r   <= '0;
      cur_r    <= '0;
      cur_v_r  <= 1'b0;
      pend_r   <= '0;
      pend_v_r <= 1'b0;
      acc_r    <= '0;
      res_r    <= '0;
    end else begin
      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (int'(clr_r) == GDEPTH - 1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (start_i) begin
            it_r  <= item_i;
            res_r <= '0;
            st_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (it_r.mode)
            MODE_GAIN_WR: begin
              st_r <= S_DONE;
              if (CMP_W'(it_r.index) >= CMP_W'(MAX_STATES)) res_r.status <= ST_BAD_STATE;
              else if (over_one)                          res_r.status <= ST_RANGE;
            end
            MODE_TIME_WR: begin
              st_r <= S_DONE;
              if (CMP_W'(it_r.index) >= CMP_W'(MAX_STATES)) res_r.status <= ST_BAD_STATE;
            end
            MODE_STING_WR: begin
              st_r <= S_DONE;
              if (CMP_W'(it_r.index) >= CMP_W'(MAX_STINGERS)) res_r.status <= ST_BAD_STING;
              else if (over_one)                            res_r.status <= ST_RANGE;
            end
            MODE_SELECT: begin
              if (CMP_W'(it_r.index) >= n_states) begin
                res_r.status <= ST_BAD_STATE;
                st_r         <= S_DONE;
              end else if (!(cur_v_r && cur_r == it_r.index && !pend_v_r)) begin
                st_r <= S_TCHK;
              end else begin
                st_r <= S_DONE;
              end
            end
            MODE_LEVEL: begin
              st_r <= S_DONE;
              if (over_one) res_r.status <= ST_RANGE;
              else          master_r     <= it_r.value;
            end
            MODE_TICK: begin
              if (pend_v_r && CMP_W'(pend_r) < n_states) st_r <= S_TCHK;
              else                                       st_r <= S_DONE;
            end
            MODE_READ: begin
              if (CMP_W'(it_r.layer_sel) < n_layers) st_r <= S_GM1;
              else                                   st_r <= S_DONE;
            end
            MODE_TRIGGER: begin
              if (CMP_W'(it_r.index) >= n_stingers) begin
                res_r.status <= ST_BAD_STING;
                st_r         <= S_DONE;
              end else begin
                st_r <= S_SRD;
              end
            end
            default: st_r <= S_DONE;
          endcase
        end
        S_TCHK: begin
          time_r <= tmem_q;
          lc_r   <= '0;
          if (it_r.mode == MODE_SELECT) st_r <= S_LRD;
          else if (tmem_q == 16'd0)     st_r <= S_DONE;
          else                          st_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (psum >= 32'(ONE_Q15)) begin
              prog_r <= ONE_Q15;
              st_r   <= S_LRD;
            end else begin
              prog_r <= psum[15:0];
              st_r   <= S_DONE;
            end
          end
        end
        S_LRD: st_r <= S_LWR;
        S_LWR: begin
          if (int'(lc_r) == MAX_LAYERS - 1) begin
            st_r <= S_DONE;
            if (it_r.mode == MODE_SELECT) begin
              prog_r <= '0;
              if (time_r == 16'd0) begin
                cur_r    <= it_r.index;
                cur_v_r  <= 1'b1;
                pend_r   <= '0;
                pend_v_r <= 1'b0;
                res_r.event_kind  <= EV_STATE;
                res_r.event_index <= it_r.index;
              end else begin
                pend_r   <= it_r.index;
                pend_v_r <= 1'b1;
              end
            end else begin
              cur_r    <= pend_r;
              cur_v_r  <= 1'b1;
              pend_r   <= '0;
              pend_v_r <= 1'b0;
              res_r.event_kind  <= EV_STATE;
              res_r.event_index <= pend_r;
            end
          end else begin
            lc_r <= lc_r + 1'b1;
            st_r <= S_LRD;
          end
        end
        S_GM1: begin
          if (pend_v_r) begin
            acc_r <= mul_p;
            st_r  <= S_GM2;
          end else begin
            acc_r <= {1'b0, lmem_q[47:32], 15'd0};
            st_r  <= S_GM3;
          end
        end
        S_GM2: begin
          acc_r <= acc_r + mul_p;
          st_r  <= S_GM3;
        end
        S_GM3: begin
          res_r.gain_out <= mul_p[30:15];
          st_r <= S_DONE;
        end
        S_SRD: begin
          res_r.event_kind        <= EV_STINGER;
          res_r.event_index       <= it_r.index;
          res_r.event_level       <= smem_q[15:0];
          res_r.event_layer       <= smem_q[18:16];
          res_r.event_layer_given <= smem_q[19];
          st_r <= S_DONE;
        end
        S_DONE: begin
          if (res_take_i) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_o               = res_r;
    res_o.settled_state = cur_r;
    res_o.settled_valid = cur_v_r;
    res_o.fading        = pend_v_r;
  end

  assign idle_o      = (st_r == S_IDLE);
  assign res_valid_o = (st_r == S_DONE);
endmodule
`default_nettype wire

/* rtl/layer_gain_crossfade_controller.sv */
// ----------------------------------------------------------------------------
// layer_gain_crossfade_controller
// Mix-state table with linear gain crossfades, stingers and gain reads.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  in_      | input     | in_valid/in_stall | mode index layer_sel layer_given value
//  out_     | output    | out_valid/out_stall | status, event fields, gain, settle
//  cfg      | APB       | psel/penable      | states, layers, stingers in use
//
//  Table writes and intensity need no table read; a gain read adds a blend
//  step while a fade is live; a stinger reads its table entry; a select
//  walks the layer slots through the per-layer memory port unless refused
//  or already settled; a tick with a live fade of nonzero time runs the
//  bit-serial divider, then walks the layer slots when the fade completes.
//  One item is in work at a time. After reset a clearing pass zeroes the
//  memories; in_stall stays high meanwhile, config writes are still taken.
//  A result waits in the output register under out_stall while the next
//  beat is accepted and worked; it is delivered once the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module layer_gain_crossfade_controller #(
  parameter int MAX_STATES   = lgc_pkg::DEF_MAX_STATES,
  parameter int MAX_LAYERS   = lgc_pkg::DEF_MAX_LAYERS,
  parameter int MAX_STINGERS = lgc_pkg::DEF_MAX_STINGERS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic [3:0]  in_index,
  input  wire logic [2:0]  in_layer_sel,
  input  wire logic        in_layer_given,
  input  wire logic [15:0] in_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [1:0]       out_event_kind,
  output logic [3:0]       out_event_index,
  output logic [2:0]       out_event_layer,
  output logic             out_event_layer_given,
  output logic [15:0]      out_event_level,
  output logic [15:0]      out_gain_out,
  output logic [3:0]       out_settled_state,
  output logic             out_settled_valid,
  output logic             out_fading,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lgc_pkg::*;

  cfg_t  cfg_r;
  item_t item;
  res_t  core_res;
  res_t  out_r;
  logic  out_valid_r;
  logic  core_idle;
  logic  core_res_valid;
  logic  out_free;
  logic  in_take;

  // register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_STATES:   cfg_r.states   <= pwdata[4:0];
        REG_LAYERS:   cfg_r.layers   <= pwdata[3:0];
        REG_STINGERS: cfg_r.stingers <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STATES:   prdata = {27'd0, cfg_r.states};
      REG_LAYERS:   prdata = {28'd0, cfg_r.layers};
      REG_STINGERS: prdata = {27'd0, cfg_r.stingers};
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // accept a beat whenever the sequencer is idle
  assign in_stall = !core_idle;
  assign in_take  = in_valid && core_idle;
  assign item     = '{mode: in_mode, index: in_index, layer_sel: in_layer_sel,
                      layer_given: in_layer_given, value: in_value};

  lgc_core #(
    .MAX_STATES   (MAX_STATES),
    .MAX_LAYERS   (MAX_LAYERS),
    .MAX_STINGERS (MAX_STINGERS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .start_i     (in_take),
    .item_i      (item),
    .idle_o      (core_idle),
    .res_valid_o (core_res_valid),
    .res_take_i  (out_free),
    .res_o       (core_res)
  );

  // output register: load when empty or draining this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else if (core_res_valid && out_free) begin
      out_valid_r <= 1'b1;
      out_r       <= core_res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_r.status;
  assign out_event_kind        = out_r.event_kind;
  assign out_event_index       = out_r.event_index;
  assign out_event_layer       = out_r.event_layer;
  assign out_event_layer_given = out_r.event_layer_given;
  assign out_event_level       = out_r.event_level;
  assign out_gain_out          = out_r.gain_out;
  assign out_settled_state     = out_r.settled_state;
  assign out_settled_valid     = out_r.settled_valid;
  assign out_fading            = out_r.fading;
endmodule
`default_nettype wire

/* rtl/lgc_checker.sv */
// ----------------------------------------------------------------------------
// lgc_checker
// Port-level checks of the crossfade controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "layer_gain_crossfade_controller_assert.svh"
module lgc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [1:0]  out_event_kind,
  input wire logic [3:0]  out_event_index,
  input wire logic [15:0] out_gain_out,
  input wire logic [3:0]  out_settled_state,
  input wire logic        out_settled_valid,
  input wire logic        out_fading
);
  import lgc_pkg::*;

  `LGC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_gain_out) && $stable(out_event_kind))
  `LGC_ASSERT_NXT(a_one_in_work, clk, rst_n, in_valid && !in_stall, in_stall)
  `LGC_ASSERT_IMP(a_err_no_event, clk, rst_n, out_valid && out_status != ST_OK,
    out_event_kind == EV_NONE && out_gain_out == 16'd0)
  `LGC_ASSERT_IMP(a_state_event, clk, rst_n, out_valid && out_event_kind == EV_STATE,
    out_settled_valid && !out_fading && out_settled_state == out_event_index)
endmodule

bind layer_gain_crossfade_controller lgc_checker u_lgc_checker (.*);
`default_nettype wire
